FILE: design/rv32idec_pkg.sv
// ----------------------------------------------------------------------------
// rv32idec_pkg
// Types and constants shared by the RV32I decoder: operation and format
// codes, base opcodes and the decoded result record.
// ----------------------------------------------------------------------------
package rv32idec_pkg;

  // base operations, in encoding order
  typedef enum logic [5:0] {
    OP_NONE  = 6'd0,
    OP_LUI   = 6'd1,
    OP_AUIPC = 6'd2,
    OP_JAL   = 6'd3,
    OP_JALR  = 6'd4,
    OP_BEQ   = 6'd5,
    OP_BNE   = 6'd6,
    OP_BLT   = 6'd7,
    OP_BGE   = 6'd8,
    OP_BLTU  = 6'd9,
    OP_BGEU  = 6'd10,
    OP_LB    = 6'd11,
    OP_LH    = 6'd12,
    OP_LW    = 6'd13,
    OP_LBU   = 6'd14,
    OP_LHU   = 6'd15,
    OP_SB    = 6'd16,
    OP_SH    = 6'd17,
    OP_SW    = 6'd18,
    OP_ADDI  = 6'd19,
    OP_SLTI  = 6'd20,
    OP_SLTIU = 6'd21,
    OP_XORI  = 6'd22,
    OP_ORI   = 6'd23,
    OP_ANDI  = 6'd24,
    OP_SLLI  = 6'd25,
    OP_SRLI  = 6'd26,
    OP_SRAI  = 6'd27,
    OP_ADD   = 6'd28,
    OP_SUB   = 6'd29,
    OP_SLL   = 6'd30,
    OP_SLT   = 6'd31,
    OP_SLTU  = 6'd32,
    OP_XOR   = 6'd33,
    OP_SRL   = 6'd34,
    OP_SRA   = 6'd35,
    OP_OR    = 6'd36,
    OP_AND   = 6'd37
  } op_e;

  // instruction formats
  typedef enum logic [2:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_U = 3'd4,
    FMT_J = 3'd5
  } fmt_e;

  // base opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  localparam int unsigned InWordW  = 32;
  localparam int unsigned OutWordW = 64;

  // decoded result
  typedef struct packed {
    logic        recognized;
    logic [31:0] immediate;
    logic [4:0]  src2_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  dest_reg;
    fmt_e        format;
    op_e         operation;
  } dec_t;

endpackage

FILE: design/rv32idec_core.sv
// ----------------------------------------------------------------------------
// rv32idec_core
// Combinational decode of one instruction: operation, format, register
// fields and sign-extended immediate.
// ----------------------------------------------------------------------------
module rv32idec_core import rv32idec_pkg::*; (
  input  logic [31:0] instr_i,
  output dec_t        dec_o
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic       b30;
  logic       sgn;
  op_e        op;
  fmt_e       fmt;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign b30 = instr_i[30];
  assign sgn = instr_i[31];

  // operation and format from opcode, funct3 and bit 30
  always_comb begin
    op  = OP_NONE;
    fmt = FMT_R;
    case (opc)
      OPC_LUI: begin
        op  = OP_LUI;
        fmt = FMT_U;
      end
      OPC_AUIPC: begin
        op  = OP_AUIPC;
        fmt = FMT_U;
      end
      OPC_JAL: begin
        op  = OP_JAL;
        fmt = FMT_J;
      end
      OPC_JALR: begin
        op  = (f3 == 3'd0) ? OP_JALR : OP_NONE;
        fmt = FMT_I;
      end
      OPC_BRANCH: begin
        fmt = FMT_B;
        case (f3)
          3'd0:    op = OP_BEQ;
          3'd1:    op = OP_BNE;
          3'd4:    op = OP_BLT;
          3'd5:    op = OP_BGE;
          3'd6:    op = OP_BLTU;
          3'd7:    op = OP_BGEU;
          default: op = OP_NONE;
        endcase
      end
      OPC_LOAD: begin
        fmt = FMT_I;
        case (f3)
          3'd0:    op = OP_LB;
          3'd1:    op = OP_LH;
          3'd2:    op = OP_LW;
          3'd4:    op = OP_LBU;
          3'd5:    op = OP_LHU;
          default: op = OP_NONE;
        endcase
      end
      OPC_STORE: begin
        fmt = FMT_S;
        case (f3)
          3'd0:    op = OP_SB;
          3'd1:    op = OP_SH;
          3'd2:    op = OP_SW;
          default: op = OP_NONE;
        endcase
      end
      OPC_OPIMM: begin
        fmt = FMT_I;
        case (f3)
          3'd0:    op = OP_ADDI;
          3'd1:    op = OP_SLLI;
          3'd2:    op = OP_SLTI;
          3'd3:    op = OP_SLTIU;
          3'd4:    op = OP_XORI;
          3'd5:    op = b30 ? OP_SRAI : OP_SRLI;
          3'd6:    op = OP_ORI;
          default: op = OP_ANDI;
        endcase
      end
      OPC_OP: begin
        fmt = FMT_R;
        case (f3)
          3'd0:    op = b30 ? OP_SUB : OP_ADD;
          3'd1:    op = OP_SLL;
          3'd2:    op = OP_SLT;
          3'd3:    op = OP_SLTU;
          3'd4:    op = OP_XOR;
          3'd5:    op = b30 ? OP_SRA : OP_SRL;
          3'd6:    op = OP_OR;
          default: op = OP_AND;
        endcase
      end
      default: begin
        op  = OP_NONE;
        fmt = FMT_R;
      end
    endcase
  end

  // register fields and immediate per format; all zero when unrecognized
  always_comb begin
    dec_o            = '0;
    dec_o.operation  = op;
    dec_o.recognized = (op != OP_NONE);
    if (op != OP_NONE) begin
      dec_o.format = fmt;
      case (fmt)
        FMT_R: begin
          dec_o.dest_reg = instr_i[11:7];
          dec_o.src1_reg = instr_i[19:15];
          dec_o.src2_reg = instr_i[24:20];
        end
        FMT_I: begin
          dec_o.dest_reg  = instr_i[11:7];
          dec_o.src1_reg  = instr_i[19:15];
          dec_o.immediate = {{20{sgn}}, instr_i[31:20]};
        end
        FMT_S: begin
          dec_o.src1_reg  = instr_i[19:15];
          dec_o.src2_reg  = instr_i[24:20];
          dec_o.immediate = {{20{sgn}}, instr_i[31:25], instr_i[11:7]};
        end
        FMT_B: begin
          dec_o.src1_reg  = instr_i[19:15];
          dec_o.src2_reg  = instr_i[24:20];
          dec_o.immediate = {{19{sgn}}, sgn, instr_i[7], instr_i[30:25],
                             instr_i[11:8], 1'b0};
        end
        FMT_U: begin
          dec_o.dest_reg  = instr_i[11:7];
          dec_o.immediate = {instr_i[31:12], 12'd0};
        end
        FMT_J: begin
          dec_o.dest_reg  = instr_i[11:7];
          dec_o.immediate = {{11{sgn}}, sgn, instr_i[19:12], instr_i[20],
                             instr_i[30:21], 1'b0};
        end
        default: begin
          dec_o.format = FMT_R;
        end
      endcase
    end
  end

endmodule

FILE: design/rv32i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// RV32I base instruction decoder with stream ports, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Every instruction word taken on the input stream gives exactly one decoded
// word on the output stream, in order. The block is a two-register pipeline:
// an input register holds the instruction, the decode logic sits between it
// and a result register. A word taken on the input passes the input register
// and then the result register before it shows as output valid, and an output
// stall can hold it in either. The block takes a new word every cycle as
// long as the output side keeps taking results; a stall on the output fills
// the input register and then holds s_axis_tready low. Unknown opcodes and
// funct3 codes give operation 0, recognized low and all other fields zero.
module rv32i_instruction_decoder import rv32idec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // instruction_word[31:0]
  input  logic [InWordW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // operation[5:0], format[8:6], dest_reg[13:9], src1_reg[18:14],
  // src2_reg[23:19], immediate[55:24], recognized[56], zero[63:57]
  output logic [OutWordW-1:0] m_axis_tdata
);

  logic        in_vld_q;
  logic [31:0] instr_q;
  logic        out_vld_q;
  dec_t        res_q;
  dec_t        dec;
  logic        out_ready;
  logic        in_ready;

  // pipeline advance conditions
  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_ready;
  assign s_axis_tready = in_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      instr_q <= s_axis_tdata;
    end
  end

  // decode logic
  rv32idec_core u_core (
    .instr_i (instr_q),
    .dec_o   (dec)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_vld_q) begin
      res_q <= dec;
    end
  end

  // output packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutWordW - $bits(dec_t)){1'b0}}, res_q};

endmodule
